FILE: rtl/core/bank_mapper_with_scanline_irq_macros.svh
// Assertion macros shared by the bank mapper RTL.
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define BMSI_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition leads to a consequence in the following cycle.
`define BMSI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMSI_ASSERT(name, clk, rst_n, prop, msg)
`define BMSI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/bmsi_pkg.sv
// Types, codes and address constants of the bank mapper.
package bmsi_pkg;

    // Input word: one CPU write or one scanline tick
    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  value;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [2:0] event_res;
        logic [2:0] slot;
        logic [7:0] bank;
        logic [1:0] mirror_mode;
    } t_out_word;

    // Event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_PRG    = 3'd1;
    localparam logic [2:0] EV_CHR    = 3'd2;
    localparam logic [2:0] EV_MIRROR = 3'd3;
    localparam logic [2:0] EV_IRQ    = 3'd4;

    // Program window codes
    localparam logic [2:0] WIN_8000 = 3'd0;
    localparam logic [2:0] WIN_A000 = 3'd1;
    localparam logic [2:0] WIN_C000 = 3'd2;

    // Action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Register addresses
    localparam logic [15:0] ADDR_PRG_8000 = 16'h8000;
    localparam logic [15:0] ADDR_MIRROR   = 16'h9000;
    localparam logic [15:0] ADDR_SWAP     = 16'h9002;
    localparam logic [15:0] ADDR_PRG_A000 = 16'hA000;
    localparam logic [15:0] ADDR_RLD_LO   = 16'hF000;
    localparam logic [15:0] ADDR_RLD_HI_0 = 16'hF002;
    localparam logic [15:0] ADDR_RLD_HI_1 = 16'hF040;
    localparam logic [15:0] ADDR_CTRL_0   = 16'hF001;
    localparam logic [15:0] ADDR_CTRL_1   = 16'hF004;
    localparam logic [15:0] ADDR_CTRL_2   = 16'hF080;
    localparam logic [15:0] ADDR_ACK_0    = 16'hF003;
    localparam logic [15:0] ADDR_ACK_1    = 16'hF006;
    localparam logic [15:0] ADDR_ACK_2    = 16'hF0C0;

    // Character bank region: upper nibble from first to last base
    localparam logic [3:0] CHR_BASE_FIRST = 4'hB;
    localparam logic [3:0] CHR_BASE_LAST  = 4'hE;

    // Character nibble offsets inside a base
    localparam logic [11:0] OFS_EVEN_LO   = 12'h000;
    localparam logic [11:0] OFS_EVEN_HI_0 = 12'h002;
    localparam logic [11:0] OFS_EVEN_HI_1 = 12'h040;
    localparam logic [11:0] OFS_ODD_LO_0  = 12'h001;
    localparam logic [11:0] OFS_ODD_LO_1  = 12'h004;
    localparam logic [11:0] OFS_ODD_LO_2  = 12'h080;
    localparam logic [11:0] OFS_ODD_HI_0  = 12'h003;
    localparam logic [11:0] OFS_ODD_HI_1  = 12'h006;
    localparam logic [11:0] OFS_ODD_HI_2  = 12'h0C0;

    localparam int CHR_SLOTS = 8;

    // Decoded operation
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_PRG_8000,
        OP_PRG_A000,
        OP_MIRROR,
        OP_SWAP,
        OP_CHR_LO,
        OP_CHR_HI,
        OP_RLD_LO,
        OP_RLD_HI,
        OP_CTRL,
        OP_ACK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] chr_slot;
    } t_cmd;

endpackage

FILE: rtl/core/bmsi_decode.sv
// Address decoder: turns one input word into an operation.
module bmsi_decode
    import bmsi_pkg::*;
(
    input  t_in_word i_word,
    output t_cmd     o_cmd
);

    logic [3:0]  base;
    logic [11:0] ofs;
    logic [3:0]  pair;
    logic        in_chr;

    assign base   = i_word.address[15:12];
    assign ofs    = i_word.address[11:0];
    assign pair   = base - CHR_BASE_FIRST;
    assign in_chr = (base >= CHR_BASE_FIRST) && (base <= CHR_BASE_LAST);

    // Match the alias list exactly
    always_comb begin
        o_cmd.op       = OP_NONE;
        o_cmd.chr_slot = '0;
        if (i_word.action == ACT_TICK) begin
            o_cmd.op = OP_TICK;
        end else if (in_chr) begin
            unique case (ofs) inside
                OFS_EVEN_LO: begin
                    o_cmd.op       = OP_CHR_LO;
                    o_cmd.chr_slot = {pair[1:0], 1'b0};
                end
                OFS_EVEN_HI_0, OFS_EVEN_HI_1: begin
                    o_cmd.op       = OP_CHR_HI;
                    o_cmd.chr_slot = {pair[1:0], 1'b0};
                end
                OFS_ODD_LO_0, OFS_ODD_LO_1, OFS_ODD_LO_2: begin
                    o_cmd.op       = OP_CHR_LO;
                    o_cmd.chr_slot = {pair[1:0], 1'b1};
                end
                OFS_ODD_HI_0, OFS_ODD_HI_1, OFS_ODD_HI_2: begin
                    o_cmd.op       = OP_CHR_HI;
                    o_cmd.chr_slot = {pair[1:0], 1'b1};
                end
                default: o_cmd.op = OP_NONE;
            endcase
        end else begin
            unique case (i_word.address) inside
                ADDR_PRG_8000:                        o_cmd.op = OP_PRG_8000;
                ADDR_MIRROR:                          o_cmd.op = OP_MIRROR;
                ADDR_SWAP:                            o_cmd.op = OP_SWAP;
                ADDR_PRG_A000:                        o_cmd.op = OP_PRG_A000;
                ADDR_RLD_LO:                          o_cmd.op = OP_RLD_LO;
                ADDR_RLD_HI_0, ADDR_RLD_HI_1:         o_cmd.op = OP_RLD_HI;
                ADDR_CTRL_0, ADDR_CTRL_1, ADDR_CTRL_2: o_cmd.op = OP_CTRL;
                ADDR_ACK_0, ADDR_ACK_1, ADDR_ACK_2:   o_cmd.op = OP_ACK;
                default:                              o_cmd.op = OP_NONE;
            endcase
        end
    end

endmodule

FILE: rtl/core/bmsi_irq.sv
// Scanline IRQ counter with reload latch, enable and rearm flag.
module bmsi_irq
    import bmsi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_value,
    output logic       o_raise
);

`include "bank_mapper_with_scanline_irq_macros.svh"

    logic [7:0] r_count, n_count;
    logic [7:0] r_reload, n_reload;
    logic       r_on, n_on;
    logic       r_rearm, n_rearm;

    // Compute the counter update for the word being retired
    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_on     = r_on;
        n_rearm  = r_rearm;
        o_raise  = 1'b0;
        if (i_fire) begin
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_on) begin
                        if (r_count == 8'hFF) begin
                            n_count = r_reload;
                            n_on    = r_rearm;
                            o_raise = 1'b1;
                        end else begin
                            n_count = r_count + 8'd1;
                        end
                    end
                end
                OP_RLD_LO: n_reload = {r_reload[7:4], i_value[3:0]};
                OP_RLD_HI: n_reload = {i_value[3:0], r_reload[3:0]};
                OP_CTRL: begin
                    n_on    = i_value[1];
                    n_rearm = i_value[0];
                    n_count = r_reload;
                end
                OP_ACK:  n_on = r_rearm;
                default: ;
            endcase
        end
    end

    // Hold the counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
            r_on     <= 1'b0;
            r_rearm  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
            r_on     <= n_on;
            r_rearm  <= n_rearm;
        end
    end

    `BMSI_ASSERT_NEXT(a_wrap_reload, i_clk, i_rst_n, o_raise, r_count == $past(r_reload), "count not reloaded on wrap")
    `BMSI_ASSERT_NEXT(a_off_holds, i_clk, i_rst_n, i_fire && i_cmd.op == OP_TICK && !r_on, $stable(r_count), "disabled counter moved")
    `BMSI_ASSERT_NEXT(a_ack_rearm, i_clk, i_rst_n, i_fire && i_cmd.op == OP_ACK, r_on == $past(r_rearm), "acknowledge did not rearm")

endmodule

FILE: rtl/core/bank_mapper_with_scanline_irq.sv
// Top level of the bank mapper with scanline IRQ counter.
//
//  channel | direction | valid      | stall      | word
//  --------+-----------+------------+------------+-------------
//  input   | in        | i_in_valid | o_in_stall | i_in_word
//  result  | out       | o_out_valid| i_out_stall| o_out_word
//
// One word is taken per cycle unless o_in_stall is high; each word goes to the input
// register, then to the result register, with decode and state update done
// combinationally between them.
// A result waiting on a stalled output leaves room for one more word in the
// input register; only then does the input stall.
// Synchronous active-low reset clears all bank, swap and IRQ state to zero.
module bank_mapper_with_scanline_irq
    import bmsi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

`include "bank_mapper_with_scanline_irq_macros.svh"

    t_in_word   r_in_word;
    logic       r_in_valid;
    t_out_word  r_out_word, n_out_word;
    logic       r_out_valid;
    logic       r_swap, n_swap;
    logic [3:0] r_chr_lo [CHR_SLOTS];
    logic [3:0] r_chr_hi [CHR_SLOTS];

    t_cmd       cmd;
    logic       in_take;
    logic       advance;
    logic       irq_raise;
    logic [3:0] chr_lo_new;
    logic [3:0] chr_hi_new;

    // Handshake between the two registers
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && r_out_valid && i_out_stall;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    bmsi_decode u_decode (
        .i_word (r_in_word),
        .o_cmd  (cmd)
    );

    bmsi_irq u_irq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_cmd   (cmd),
        .i_value (r_in_word.value),
        .o_raise (irq_raise)
    );

    // Merge the written nibble with the stored one
    assign chr_lo_new = (cmd.op == OP_CHR_LO) ? r_in_word.value[3:0] : r_chr_lo[cmd.chr_slot];
    assign chr_hi_new = (cmd.op == OP_CHR_HI) ? r_in_word.value[3:0] : r_chr_hi[cmd.chr_slot];

    // Build the result word
    always_comb begin
        n_out_word = '0;
        n_swap     = r_swap;
        case (cmd.op)
            OP_PRG_8000: begin
                n_out_word.event_res = EV_PRG;
                n_out_word.slot      = r_swap ? WIN_C000 : WIN_8000;
                n_out_word.bank      = r_in_word.value;
            end
            OP_PRG_A000: begin
                n_out_word.event_res = EV_PRG;
                n_out_word.slot      = WIN_A000;
                n_out_word.bank      = r_in_word.value;
            end
            OP_MIRROR: begin
                n_out_word.event_res   = EV_MIRROR;
                n_out_word.mirror_mode = r_in_word.value[1:0];
            end
            OP_SWAP: n_swap = r_in_word.value[1];
            OP_CHR_LO, OP_CHR_HI: begin
                n_out_word.event_res = EV_CHR;
                n_out_word.slot      = cmd.chr_slot;
                n_out_word.bank      = {chr_hi_new, chr_lo_new};
            end
            OP_TICK: begin
                if (irq_raise) begin
                    n_out_word.event_res = EV_IRQ;
                end
            end
            default: ;
        endcase
    end

    // Hold the input word until it can advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // Load the result register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    // Update swap bit and character nibbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b0;
            for (int i = 0; i < CHR_SLOTS; i++) begin
                r_chr_lo[i] <= '0;
                r_chr_hi[i] <= '0;
            end
        end else if (advance) begin
            r_swap <= n_swap;
            if (cmd.op == OP_CHR_LO || cmd.op == OP_CHR_HI) begin
                r_chr_lo[cmd.chr_slot] <= chr_lo_new;
                r_chr_hi[cmd.chr_slot] <= chr_hi_new;
            end
        end
    end

    `BMSI_ASSERT(a_none_zero, i_clk, i_rst_n, o_out_valid && o_out_word.event_res == EV_NONE |-> o_out_word.slot == '0 && o_out_word.bank == '0 && o_out_word.mirror_mode == '0, "none event carries data")
    `BMSI_ASSERT(a_mirror_only, i_clk, i_rst_n, o_out_valid && o_out_word.event_res != EV_MIRROR |-> o_out_word.mirror_mode == '0, "mirror mode outside mirror event")
    `BMSI_ASSERT(a_event_range, i_clk, i_rst_n, o_out_valid |-> o_out_word.event_res <= EV_IRQ, "event code out of range")
    `BMSI_ASSERT_NEXT(a_keep_pending, i_clk, i_rst_n, r_in_valid && r_out_valid && i_out_stall, r_in_valid && $stable(r_in_word), "pending word lost")
    `BMSI_ASSERT(a_irq_from_tick, i_clk, i_rst_n, irq_raise |-> advance && cmd.op == OP_TICK, "IRQ without tick")

endmodule

FILE: test/tb.sv
// Testbench of the bank mapper: directed and random CPU writes and scanline ticks vs. a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bmsi_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    bank_mapper_with_scanline_irq DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #2 i_clk = ~i_clk;

    // Predicted mapper state
    logic [3:0] chr_lo_q [CHR_SLOTS] = '{default: '0};
    logic [3:0] chr_hi_q [CHR_SLOTS] = '{default: '0};
    logic       swap_q = 1'b0;
    logic       irq_on_q = 1'b0;
    logic       irq_rearm_q = 1'b0;
    logic [7:0] irq_cnt_q = '0;
    logic [7:0] irq_rld_q = '0;

    t_in_word  pending_words [$];
    t_out_word expected_results [$];
    int        drain_points [$];
    int        issued_cnt = 0;
    int        gap_left = 0;
    int        result_cnt = 0;
    int        stall_left = 0;
    int        mismatch_cnt = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    logic      hold_out = 1'b0;

    // Address aliases used to build stimulus
    logic [15:0] bank_addrs [4] = '{ADDR_PRG_8000, ADDR_MIRROR, ADDR_SWAP, ADDR_PRG_A000};
    logic [15:0] irq_addrs [9] = '{ADDR_RLD_LO, ADDR_RLD_HI_0, ADDR_RLD_HI_1,
                                   ADDR_CTRL_0, ADDR_CTRL_1, ADDR_CTRL_2,
                                   ADDR_ACK_0, ADDR_ACK_1, ADDR_ACK_2};
    logic [15:0] ctrl_addrs [3] = '{ADDR_CTRL_0, ADDR_CTRL_1, ADDR_CTRL_2};
    logic [15:0] ack_addrs [3] = '{ADDR_ACK_0, ADDR_ACK_1, ADDR_ACK_2};
    logic [15:0] rld_hi_addrs [2] = '{ADDR_RLD_HI_0, ADDR_RLD_HI_1};
    logic [11:0] chr_offsets [9] = '{OFS_EVEN_LO, OFS_EVEN_HI_0, OFS_EVEN_HI_1,
                                     OFS_ODD_LO_0, OFS_ODD_LO_1, OFS_ODD_LO_2,
                                     OFS_ODD_HI_0, OFS_ODD_HI_1, OFS_ODD_HI_2};

    // Advance the predicted state by one word and return the expected result
    function automatic t_out_word map_word(t_in_word w);
        t_out_word  r;
        logic [3:0] base;
        logic [2:0] cs;
        logic       is_chr;
        logic       hi;
        r = '0;
        if (w.action == ACT_TICK) begin
            if (irq_on_q) begin
                if (irq_cnt_q == 8'hFF) begin
                    irq_cnt_q = irq_rld_q;
                    irq_on_q = irq_rearm_q;
                    r.event_res = EV_IRQ;
                end else begin
                    irq_cnt_q = irq_cnt_q + 8'd1;
                end
            end
            return r;
        end
        // Decode the character nibble aliases first
        base = w.address[15:12];
        is_chr = 1'b0;
        hi = 1'b0;
        cs = '0;
        if (base >= CHR_BASE_FIRST && base <= CHR_BASE_LAST) begin
            is_chr = 1'b1;
            case (w.address[11:0])
                OFS_EVEN_LO: begin
                    cs[0] = 1'b0; hi = 1'b0;
                end
                OFS_EVEN_HI_0, OFS_EVEN_HI_1: begin
                    cs[0] = 1'b0; hi = 1'b1;
                end
                OFS_ODD_LO_0, OFS_ODD_LO_1, OFS_ODD_LO_2: begin
                    cs[0] = 1'b1; hi = 1'b0;
                end
                OFS_ODD_HI_0, OFS_ODD_HI_1, OFS_ODD_HI_2: begin
                    cs[0] = 1'b1; hi = 1'b1;
                end
                default: begin
                    is_chr = 1'b0;
                end
            endcase
            cs[2:1] = 2'(base - CHR_BASE_FIRST);
        end
        if (is_chr) begin
            if (hi) chr_hi_q[cs] = w.value[3:0];
            else chr_lo_q[cs] = w.value[3:0];
            r.event_res = EV_CHR;
            r.slot = cs;
            r.bank = {chr_hi_q[cs], chr_lo_q[cs]};
            return r;
        end
        // Remaining registers decode by exact address
        case (w.address)
            ADDR_PRG_8000: begin
                r.event_res = EV_PRG;
                r.slot = swap_q ? WIN_C000 : WIN_8000;
                r.bank = w.value;
            end
            ADDR_MIRROR: begin
                r.event_res = EV_MIRROR;
                r.mirror_mode = w.value[1:0];
            end
            ADDR_SWAP: swap_q = w.value[1];
            ADDR_PRG_A000: begin
                r.event_res = EV_PRG;
                r.slot = WIN_A000;
                r.bank = w.value;
            end
            ADDR_RLD_LO: irq_rld_q[3:0] = w.value[3:0];
            ADDR_RLD_HI_0, ADDR_RLD_HI_1: irq_rld_q[7:4] = w.value[3:0];
            ADDR_CTRL_0, ADDR_CTRL_1, ADDR_CTRL_2: begin
                irq_on_q = w.value[1];
                irq_rearm_q = w.value[0];
                irq_cnt_q = irq_rld_q;
            end
            ADDR_ACK_0, ADDR_ACK_1, ADDR_ACK_2: irq_on_q = irq_rearm_q;
            default: ;
        endcase
        return r;
    endfunction

    // Idle length: mostly none or short, a few long, and idle-free stretches
    function automatic int idle_span(int n);
        int r;
        if (n[8:7] == 2'b01) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(9, 4);
        return $urandom_range(40, 15);
    endfunction

    task automatic add_word(logic act, logic [15:0] addr, logic [7:0] val);
        t_in_word w;
        w.action = act;
        w.address = addr;
        w.value = val;
        pending_words.push_back(w);
    endtask

    task automatic add_noise();
        add_word(1'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic add_chr_write();
        add_word(ACT_WRITE, {4'(CHR_BASE_FIRST + 4'($urandom_range(3))),
                 chr_offsets[$urandom_range(8)]}, 8'($urandom));
    endtask

    // Reload, arm and tick the counter so it can wrap, with character writes mixed in
    task automatic add_irq_sequence();
        int n;
        n = $urandom_range(24);
        add_word(ACT_WRITE, ADDR_RLD_LO, 8'($urandom));
        add_word(ACT_WRITE, rld_hi_addrs[$urandom_range(1)],
                 {4'($urandom), ($urandom_range(3) != 0) ? 4'hF : 4'($urandom)});
        add_word(ACT_WRITE, ctrl_addrs[$urandom_range(2)],
                 {6'($urandom), ($urandom_range(4) != 0), 1'($urandom)});
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(7) == 0) add_chr_write();
            add_word(ACT_TICK, 16'($urandom), 8'($urandom));
        end
        if ($urandom_range(1) == 0) add_word(ACT_WRITE, ack_addrs[$urandom_range(2)], 8'($urandom));
    endtask

    // Sender: offer pending words, hold a stalled word, pause at drain points
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid) expected_results.push_back(map_word(in_word));
            if (drain_points.size() > 0 && issued_cnt == drain_points[0] &&
                    expected_results.size() == 0)
                void'(drain_points.pop_front());
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_words.size() > 0 &&
                    !(drain_points.size() > 0 && issued_cnt == drain_points[0])) begin
                in_word <= pending_words.pop_front();
                in_valid <= 1'b1;
                issued_cnt++;
                gap_left = idle_span(issued_cnt);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so the block fills and stalls its input
    always @(posedge i_clk) begin
        if (!hold_done && result_cnt >= 600) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) hold_left--;
        hold_out <= hold_left > 0;
    end

    // Receiver: check each accepted result word against the oldest prediction
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                result_cnt++;
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result word with no prediction: ev=%0d slot=%0d bank=%0h mir=%0d",
                                 $realtime, out_word.event_res, out_word.slot,
                                 out_word.bank, out_word.mirror_mode);
                end else begin
                    exp_word = expected_results.pop_front();
                    if (out_word.event_res !== exp_word.event_res ||
                            out_word.slot !== exp_word.slot ||
                            out_word.bank !== exp_word.bank ||
                            out_word.mirror_mode !== exp_word.mirror_mode) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t: result %0d exp ev=%0d slot=%0d bank=%0h mir=%0d, got ev=%0d slot=%0d bank=%0h mir=%0d",
                                     $realtime, result_cnt, exp_word.event_res, exp_word.slot,
                                     exp_word.bank, exp_word.mirror_mode, out_word.event_res,
                                     out_word.slot, out_word.bank, out_word.mirror_mode);
                    end
                end
            end
            if (stall_left > 0) stall_left--;
            else stall_left = idle_span(result_cnt + 128);
            out_stall <= hold_out || stall_left > 0;
        end
    end

    initial begin
        int r;
        // Directed: bank registers, swap, mirroring, character nibbles
        add_word(ACT_WRITE, ADDR_PRG_8000, 8'hFF);
        add_word(ACT_WRITE, ADDR_PRG_A000, 8'h00);
        add_word(ACT_WRITE, ADDR_MIRROR, 8'hFF);
        add_word(ACT_WRITE, ADDR_MIRROR, 8'h01);
        add_word(ACT_WRITE, ADDR_SWAP, 8'hFF);
        add_word(ACT_WRITE, ADDR_PRG_8000, 8'h5A);
        add_word(ACT_WRITE, ADDR_SWAP, 8'hFD);
        add_word(ACT_WRITE, {CHR_BASE_FIRST, OFS_EVEN_LO}, 8'hFF);
        add_word(ACT_WRITE, {CHR_BASE_FIRST, OFS_EVEN_HI_1}, 8'hF0);
        add_word(ACT_WRITE, {CHR_BASE_LAST, OFS_ODD_HI_2}, 8'h0F);
        add_word(ACT_WRITE, {CHR_BASE_LAST, OFS_ODD_LO_2}, 8'hA5);
        add_word(ACT_WRITE, 16'hC004, 8'h3C);
        add_word(ACT_WRITE, 16'hD003, 8'h96);
        // Unmatched addresses and a tick while the counter is off
        add_word(ACT_WRITE, 16'h0000, 8'hFF);
        add_word(ACT_WRITE, 16'hFFFF, 8'h00);
        add_word(ACT_WRITE, 16'hB008, 8'hFF);
        add_word(ACT_TICK, ADDR_PRG_8000, 8'hFF);
        // Counter wrap with rearm set, then with rearm clear, then acknowledge
        add_word(ACT_WRITE, ADDR_RLD_LO, 8'hFE);
        add_word(ACT_WRITE, ADDR_RLD_HI_1, 8'hFF);
        add_word(ACT_WRITE, ADDR_CTRL_2, 8'h03);
        add_word(ACT_TICK, 16'h0000, 8'h00);
        add_word(ACT_TICK, 16'hFFFF, 8'hFF);
        add_word(ACT_WRITE, ADDR_CTRL_0, 8'h02);
        add_word(ACT_TICK, 16'h0000, 8'h00);
        add_word(ACT_TICK, 16'h0000, 8'h00);
        add_word(ACT_TICK, 16'h0000, 8'h00);
        add_word(ACT_WRITE, ADDR_CTRL_1, 8'h01);
        add_word(ACT_WRITE, ADDR_ACK_2, 8'h00);
        // Sender waits for all results after the directed part and once later
        drain_points.push_back(pending_words.size());
        drain_points.push_back(1100);

        // Random: mostly well-formed register use, some noise
        while (pending_words.size() < 2030) begin
            r = $urandom_range(99);
            if (r < 25) add_irq_sequence();
            else if (r < 45) add_word(ACT_TICK, 16'($urandom), 8'($urandom));
            else if (r < 65) add_chr_write();
            else if (r < 75) add_word(ACT_WRITE, bank_addrs[$urandom_range(3)], 8'($urandom));
            else if (r < 83) add_word(ACT_WRITE, irq_addrs[$urandom_range(8)], 8'($urandom));
            else add_noise();
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || in_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
